// ===== rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int INDEX_W = 12;
    localparam int THR_W   = 16;

    // Arithmetic widths: area is size * size, union may reach two areas,
    // product is threshold * union.
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int UNION_W = AREA_W + 1;
    localparam int PROD_W  = THR_W + UNION_W;

    // Reset value of the overlap threshold (about 0.45 in Q0.16)
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    // Parameter defaults
    localparam int MAX_KEPT_DEF  = 64;
    localparam int MAX_BOXES_DEF = 4096;

    // One box as held in the store
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } box_t;

    // Outcome of one overlap test
    typedef struct packed {
        logic valid;
        logic hit;
    } cmp_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } gbs_state_t;

endpackage

// ===== rtl/gbs_box_if.sv =====
// ----------------------------------------------------------------------------
// gbs_box_if
// Valid/ready channel carrying one detection box per item.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    import gbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic        [SIZE_W-1:0]  box_width;
    logic        [SIZE_W-1:0]  box_height;
    logic                      frame_end;

    modport source (
        output valid, box_left, box_top, box_width, box_height, frame_end,
        input  ready
    );

    modport sink (
        input  valid, box_left, box_top, box_width, box_height, frame_end,
        output ready
    );
endinterface

// ===== rtl/gbs_res_if.sv =====
// ----------------------------------------------------------------------------
// gbs_res_if
// Valid/ready channel carrying one suppression verdict per item.
// ----------------------------------------------------------------------------
interface gbs_res_if;
    import gbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               kept;
    logic [INDEX_W-1:0] box_index;
    logic               store_full;
    logic               frame_done;

    modport source (
        output valid, kept, box_index, store_full, frame_done,
        input  ready
    );

    modport sink (
        input  valid, kept, box_index, store_full, frame_done,
        output ready
    );
endinterface

// ===== rtl/gbs_iou_unit.sv =====
// ----------------------------------------------------------------------------
// gbs_iou_unit
// Pipelined overlap test: intersection * 65536 > threshold * union.
// Five register stages, one stored box accepted per cycle.
// ----------------------------------------------------------------------------
module gbs_iou_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [gbs_pkg::THR_W-1:0]         threshold,
    input  gbs_pkg::box_t                     new_box,
    input  logic [gbs_pkg::AREA_W-1:0]        new_area,
    input  logic                              kept_valid,
    input  gbs_pkg::box_t                     kept_box,
    output gbs_pkg::cmp_t                     result,
    output logic                              busy
);
    import gbs_pkg::*;

    localparam int EDGE_W = COORD_W + 1;

    // Stage 1: overlap extents
    logic signed [EDGE_W-1:0] nl, nr, nt, nb, kl, kr, kt, kb;
    logic signed [EDGE_W-1:0] x0, x1, y0, y1;
    logic [SIZE_W-1:0]        ox_next, oy_next;

    logic                     s1_valid_reg;
    logic [SIZE_W-1:0]        ox_reg, oy_reg, kw_reg, kh_reg;

    // Stage 2: areas
    logic                     s2_valid_reg;
    logic [AREA_W-1:0]        inter2_reg, karea_reg;

    // Stage 3: union
    logic                     s3_valid_reg;
    logic [AREA_W-1:0]        inter3_reg;
    logic [UNION_W-1:0]       union_reg;

    // Stage 4: threshold product
    logic                     s4_valid_reg;
    logic [AREA_W-1:0]        inter4_reg;
    logic [PROD_W-1:0]        prod_reg;

    // Stage 5: verdict
    logic                     s5_valid_reg;
    logic                     hit_reg;

    // Edges, all one bit wider than the inputs
    always_comb
    begin
        nl = EDGE_W'(new_box.left);
        nt = EDGE_W'(new_box.top);
        kl = EDGE_W'(kept_box.left);
        kt = EDGE_W'(kept_box.top);
        nr = nl + $signed({2'b00, new_box.width});
        nb = nt + $signed({2'b00, new_box.height});
        kr = kl + $signed({2'b00, kept_box.width});
        kb = kt + $signed({2'b00, kept_box.height});
        x0 = (nl > kl) ? nl : kl;
        y0 = (nt > kt) ? nt : kt;
        x1 = (nr < kr) ? nr : kr;
        y1 = (nb < kb) ? nb : kb;
        // touching or disjoint gives zero extent; a positive extent fits a size
        ox_next = (x1 > x0) ? SIZE_W'(x1 - x0) : '0;
        oy_next = (y1 > y0) ? SIZE_W'(y1 - y0) : '0;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= kept_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        kw_reg     <= kept_box.width;
        kh_reg     <= kept_box.height;

        inter2_reg <= AREA_W'(ox_reg) * AREA_W'(oy_reg);
        karea_reg  <= AREA_W'(kw_reg) * AREA_W'(kh_reg);

        inter3_reg <= inter2_reg;
        union_reg  <= UNION_W'(new_area) + UNION_W'(karea_reg) - UNION_W'(inter2_reg);

        inter4_reg <= inter3_reg;
        prod_reg   <= PROD_W'(threshold) * PROD_W'(union_reg);

        hit_reg    <= PROD_W'({inter4_reg, 16'h0000}) > prod_reg;
    end

    assign result.valid = s5_valid_reg;
    assign result.hit   = hit_reg;
    assign busy = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg | s5_valid_reg;

endmodule

// ===== rtl/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of score-sorted boxes against a store of kept boxes.
// Per item: one read per stored box, then the read register and overlap
//   pipeline drain, then the result is registered; an empty store goes straight to the result.
// Input: a new item is taken only after the last item's result is registered,
//   which waits while an earlier result is still held on the result channel.
// Reset: no clearing pass; count, frame position and threshold reset at once.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
    parameter int MAX_KEPT  = gbs_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    gbs_box_if.sink                     boxes,
    gbs_res_if.source                   results,
    input  logic                        cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]   cfg_wr_data
);
    import gbs_pkg::*;

    localparam int ADDR_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);
    localparam int SAT_INT  = (MAX_BOXES - 1 < 4095) ? MAX_BOXES - 1 : 4095;
    localparam logic [INDEX_W-1:0] IDX_SAT = INDEX_W'(SAT_INT);
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_KEPT);

    gbs_state_t          state_reg, state_next;

    logic [THR_W-1:0]    thr_reg;
    box_t                box_reg;
    logic                frame_end_reg;
    logic [AREA_W-1:0]   area_reg;
    logic                suppress_reg;
    logic [ADDR_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]    kept_count_reg;
    logic [INDEX_W-1:0]  frame_pos_reg;

    box_t                kept_mem [MAX_KEPT];
    box_t                rd_data_reg;
    logic                rd_valid_reg;

    logic                out_valid_reg;
    logic                out_kept_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_full_reg;
    logic                out_done_reg;

    logic                in_accept;
    logic                issue;
    logic                scan_last;
    logic                finish_go;
    logic                has_room;
    logic                mem_we;
    cmp_t                cmp;
    logic                cmp_busy;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    // Sequencer outputs
    always_comb
    begin
        boxes.ready = 1'b0;
        issue       = 1'b0;
        finish_go   = 1'b0;
        case (state_reg)
            ST_IDLE:   boxes.ready = 1'b1;
            ST_SCAN:   issue       = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: finish_go   = !out_valid_reg || results.ready;
            default:   ;
        endcase
    end

    assign in_accept = boxes.valid && boxes.ready;
    assign scan_last = (CNT_W'(scan_idx_reg) == kept_count_reg - CNT_W'(1));
    assign has_room  = kept_count_reg < CNT_MAX;
    assign mem_we    = finish_go && !suppress_reg && has_room;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                    state_next = (kept_count_reg == '0) ? ST_FINISH : ST_SCAN;
            ST_SCAN:
                if (scan_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!rd_valid_reg && !cmp_busy)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (finish_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Latch the incoming box and its area
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            box_reg.left   <= boxes.box_left;
            box_reg.top    <= boxes.box_top;
            box_reg.width  <= boxes.box_width;
            box_reg.height <= boxes.box_height;
            frame_end_reg  <= boxes.frame_end;
            area_reg       <= AREA_W'(boxes.box_width) * AREA_W'(boxes.box_height);
        end
    end

    // Scan address and suppression flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            suppress_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                scan_idx_reg <= '0;
            else if (issue)
                scan_idx_reg <= scan_idx_reg + ADDR_W'(1);

            if (in_accept)
                suppress_reg <= 1'b0;
            else if (cmp.valid && cmp.hit)
                suppress_reg <= 1'b1;
        end
    end

    // Kept box store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            kept_mem[kept_count_reg[ADDR_W-1:0]] <= box_reg;
        if (issue)
            rd_data_reg <= kept_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= issue;
    end

    // Overlap test pipeline
    gbs_iou_unit u_iou (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (thr_reg),
        .new_box    (box_reg),
        .new_area   (area_reg),
        .kept_valid (rd_valid_reg),
        .kept_box   (rd_data_reg),
        .result     (cmp),
        .busy       (cmp_busy)
    );

    // Store count and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            frame_pos_reg  <= '0;
        end
        else if (finish_go)
        begin
            if (frame_end_reg)
            begin
                kept_count_reg <= '0;
                frame_pos_reg  <= '0;
            end
            else
            begin
                if (mem_we)
                    kept_count_reg <= kept_count_reg + CNT_W'(1);
                if (frame_pos_reg < IDX_SAT)
                    frame_pos_reg <= frame_pos_reg + INDEX_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_go)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_kept_reg  <= !suppress_reg;
            out_index_reg <= frame_pos_reg;
            out_full_reg  <= !suppress_reg && !has_room;
            out_done_reg  <= frame_end_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.kept       = out_kept_reg;
    assign results.box_index  = out_index_reg;
    assign results.store_full = out_full_reg;
    assign results.frame_done = out_done_reg;

`ifndef SYNTH
    // store never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_MAX)
        else $error("kept count beyond store depth");

    // pipeline is empty whenever a new box may be taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cmp_busy && !rd_valid_reg)
        else $error("overlap pipeline busy in idle");

    // test results only arrive while scanning or draining
    a_cmp_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmp.valid |-> state_reg == ST_SCAN || state_reg == ST_DRAIN)
        else $error("overlap result outside scan");

    // last box of a frame clears the store
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go && frame_end_reg |=> kept_count_reg == '0 && frame_pos_reg == '0)
        else $error("frame end did not clear state");

    // a full flag only goes with a kept box
    a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.store_full |-> results.kept)
        else $error("store full on suppressed box");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for greedy_box_suppression. Score-sorted boxes are sent in frames
// over the valid/ready box channel and each verdict is checked against an
// in-bench overlap predictor or a typed table verdict. A short directed table
// comes first (touching and empty boxes, zero areas, coordinate extremes,
// frame ends). Random frames follow under several overlap thresholds, with
// frames that overflow the store. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    localparam int KEPT_DEPTH  = MAX_KEPT_DEF;
    localparam int BOX_LIMIT   = MAX_BOXES_DEF;
    localparam int INDEX_SAT   = (BOX_LIMIT - 1 < 4095) ? BOX_LIMIT - 1 : 4095;
    localparam int DRAIN_PAD   = KEPT_DEPTH + 8;
    localparam int PHASE_ITEMS = 290;

    // One verdict as seen on the result channel
    typedef struct packed {
        logic               kept;
        logic [INDEX_W-1:0] index;
        logic               full;
        logic               done;
    } verdict_t;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        box_t     shape;
        logic     last;
        logic     typed;
        verdict_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 16;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // first box after reset, then an exact copy of it
        '{'{16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b1, '{1'b1, 12'd0, 1'b0, 1'b0}},
        '{'{16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b1, '{1'b0, 12'd1, 1'b0, 1'b0}},
        // edges that only touch
        '{'{16'sd160, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b1, '{1'b1, 12'd2, 1'b0, 1'b0}},
        '{'{16'sd0, 16'sd160, 15'd160, 15'd160}, 1'b0, 1'b1, '{1'b1, 12'd3, 1'b0, 1'b0}},
        // zero area box, then another on top of it: zero union
        '{'{16'sd500, 16'sd500, 15'd0, 15'd0}, 1'b0, 1'b1, '{1'b1, 12'd4, 1'b0, 1'b0}},
        '{'{16'sd500, 16'sd500, 15'd0, 15'd0}, 1'b0, 1'b1, '{1'b1, 12'd5, 1'b0, 1'b0}},
        // coordinate and size extremes
        '{'{16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff}, 1'b0, 1'b0, '0},
        '{'{16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff}, 1'b0, 1'b0, '0},
        '{'{16'sh8000, 16'sh7fff, 15'd0, 15'h7fff}, 1'b0, 1'b0, '0},
        // partial overlaps either side of the default threshold
        '{'{16'sd80, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b0, '0},
        '{'{16'sd40, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b0, '0},
        '{'{16'sd16, 16'sd16, 15'd32, 15'd32}, 1'b0, 1'b0, '0},
        // end of frame
        '{'{16'sd1000, 16'sd1000, 15'd16, 15'd16}, 1'b1, 1'b1, '{1'b1, 12'd12, 1'b0, 1'b1}},
        // store cleared by the frame end
        '{'{16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b0, 1'b1, '{1'b1, 12'd0, 1'b0, 1'b0}},
        '{'{16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b1, 1'b1, '{1'b0, 12'd1, 1'b0, 1'b1}},
        // single box frame
        '{'{16'sd7, 16'sd7, 15'd7, 15'd7}, 1'b1, 1'b1, '{1'b1, 12'd0, 1'b0, 1'b1}}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THR_W-1:0]    cfg_wr_data;

    gbs_box_if box_ch ();
    gbs_res_if res_ch ();

    greedy_box_suppression #(
        .MAX_KEPT  (KEPT_DEPTH),
        .MAX_BOXES (BOX_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .boxes       (box_ch),
        .results     (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state: stored boxes, count, frame position, threshold
    box_t             kept_store [KEPT_DEPTH];
    int               stored_count = 0;
    int               frame_pos    = 0;
    logic [THR_W-1:0] iou_thr      = THR_RESET;

    verdict_t         verdict_q [$];
    int               err_total   = 0;
    int               burst_left  = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, well beyond the slowest legal run
    initial
    begin : run_limit
        #(50_000_000);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Overlap predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] box_area(input box_t b);
        return 64'(b.width) * 64'(b.height);
    endfunction

    function automatic logic [63:0] overlap_area(input box_t p, input box_t q);
        int pl, pt, pw, ph, ql, qt, qw, qh;
        int x0, y0, x1, y1;
        pl = $signed(p.left);
        pt = $signed(p.top);
        pw = p.width;
        ph = p.height;
        ql = $signed(q.left);
        qt = $signed(q.top);
        qw = q.width;
        qh = q.height;
        x0 = (pl > ql) ? pl : ql;
        y0 = (pt > qt) ? pt : qt;
        x1 = (pl + pw < ql + qw) ? pl + pw : ql + qw;
        y1 = (pt + ph < qt + qh) ? pt + ph : qt + qh;
        if (x1 <= x0 || y1 <= y0)
            return 64'd0;
        return 64'(x1 - x0) * 64'(y1 - y0);
    endfunction

    // Verdict for one accepted box; advances the predictor state
    function automatic verdict_t judge_box(input box_t b, input logic last);
        verdict_t    v;
        logic [63:0] new_area;
        logic [63:0] inter;
        logic [63:0] uni;
        logic        keep;
        int          i;
        keep     = 1'b1;
        new_area = box_area(b);
        for (i = 0; i < stored_count; i++)
        begin
            inter = overlap_area(b, kept_store[i]);
            uni   = new_area + box_area(kept_store[i]) - inter;
            if ((inter << 16) > 64'(iou_thr) * uni)
                keep = 1'b0;
        end
        v.kept  = keep;
        v.index = INDEX_W'(frame_pos);
        v.full  = 1'b0;
        v.done  = last;
        if (keep)
        begin
            if (stored_count < KEPT_DEPTH)
            begin
                kept_store[stored_count] = b;
                stored_count++;
            end
            else
                v.full = 1'b1;
        end
        if (frame_pos < INDEX_SAT)
            frame_pos++;
        if (last)
        begin
            stored_count = 0;
            frame_pos    = 0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Box generators
    // ------------------------------------------------------------------------
    // Disjoint boxes on a 512 grid, to fill the store
    function automatic box_t grid_box(input int k);
        box_t b;
        b.left   = 16'(-4096 + (k % 16) * 512);
        b.top    = 16'(-4096 + ((k / 16) % 16) * 512);
        b.width  = 15'($urandom_range(256, 400));
        b.height = 15'($urandom_range(256, 400));
        return b;
    endfunction

    // Nearby copy of an earlier box
    function automatic box_t jitter_box(input box_t b, input int span);
        box_t j;
        j.left   = b.left + 16'($urandom_range(0, 2 * span)) - 16'(span);
        j.top    = b.top + 16'($urandom_range(0, 2 * span)) - 16'(span);
        j.width  = b.width + 15'($urandom_range(0, 2 * span)) - 15'(span);
        j.height = b.height + 15'($urandom_range(0, 2 * span)) - 15'(span);
        return j;
    endfunction

    // Box in a busy central region
    function automatic box_t cluster_box();
        box_t b;
        b.left   = 16'($urandom_range(0, 4000) - 2000);
        b.top    = 16'($urandom_range(0, 4000) - 2000);
        b.width  = ($urandom_range(0, 15) == 0) ? 15'd0 : 15'($urandom_range(1, 1600));
        b.height = ($urandom_range(0, 15) == 0) ? 15'd0 : 15'($urandom_range(1, 1600));
        return b;
    endfunction

    // Any box at all, sizes sometimes pinned to their extremes
    function automatic box_t wild_box();
        box_t b;
        b.left   = 16'($urandom);
        b.top    = 16'($urandom);
        b.width  = 15'($urandom);
        b.height = 15'($urandom);
        if ($urandom_range(0, 3) == 0)
            b.width = $urandom_range(0, 1) ? 15'h7fff : 15'd0;
        if ($urandom_range(0, 3) == 0)
            b.height = $urandom_range(0, 1) ? 15'h7fff : 15'd0;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Box channel driver
    // ------------------------------------------------------------------------
    // Send one item; queue the typed verdict if given, else the predicted one
    task automatic drive_box(input box_t b, input logic last, input logic typed,
                             input verdict_t typed_v);
        verdict_t v;
        int       gap;
        box_ch.valid      <= 1'b1;
        box_ch.box_left   <= b.left;
        box_ch.box_top    <= b.top;
        box_ch.box_width  <= b.width;
        box_ch.box_height <= b.height;
        box_ch.frame_end  <= last;
        @(posedge clk);
        while (!box_ch.ready)
            @(posedge clk);
        v = judge_box(b, last);
        verdict_q = {verdict_q, (typed ? typed_v : v)};
        // bursts with random gaps between them
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 30);
            if (gap > 0)
            begin
                box_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every verdict has come back
    task automatic hold_until_drained();
        box_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] thr);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        iou_thr = thr;
        cfg_wr_en <= 1'b0;
    endtask

    // One frame of boxes; fill frames are mostly disjoint to overflow the store
    task automatic send_frame(input int n_boxes, input bit fill);
        box_t frame_boxes [$];
        box_t b;
        int   k;
        int   pick;
        for (k = 0; k < n_boxes; k++)
        begin
            pick = $urandom_range(0, 99);
            if (fill && pick < 85)
                b = grid_box(k);
            else if (frame_boxes.size() != 0 && pick < 45)
                b = jitter_box(frame_boxes[$urandom_range(0, frame_boxes.size() - 1)],
                               1 << $urandom_range(0, 9));
            else if (pick < 85)
                b = cluster_box();
            else
                b = wild_box();
            frame_boxes = {frame_boxes, b};
            drive_box(b, k == n_boxes - 1, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: stalls in changing styles
    // ------------------------------------------------------------------------
    initial
    begin : result_stalls
        int stall_left;
        int style;
        int style_left;
        stall_left = 0;
        style      = 0;
        style_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(50, 400);
            end
            style_left--;
            if (stall_left > 0)
                stall_left--;
            else
                case (style)
                    1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                    2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
                    3: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
                    default: ;
                endcase
            res_ch.ready <= (stall_left == 0);
        end
    end

    // Compare each verdict with the oldest one waiting
    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict with none waiting: index %0d", res_ch.box_index);
                err_total++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (res_ch.kept !== want.kept)
                begin
                    $error("kept: expected %0d, actual %0d", want.kept, res_ch.kept);
                    err_total++;
                end
                if (res_ch.box_index !== want.index)
                begin
                    $error("box_index: expected %0d, actual %0d", want.index,
                           res_ch.box_index);
                    err_total++;
                end
                if (res_ch.store_full !== want.full)
                begin
                    $error("store_full: expected %0d, actual %0d", want.full,
                           res_ch.store_full);
                    err_total++;
                end
                if (res_ch.frame_done !== want.done)
                begin
                    $error("frame_done: expected %0d, actual %0d", want.done,
                           res_ch.frame_done);
                    err_total++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [THR_W-1:0] phase_thr [6];
        int               row;
        int               phase;
        int               sent;
        int               n_boxes;
        bit               fill;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        box_ch.valid      <= 1'b0;
        box_ch.box_left   <= '0;
        box_ch.box_top    <= '0;
        box_ch.box_width  <= '0;
        box_ch.box_height <= '0;
        box_ch.frame_end  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset threshold
        for (row = 0; row < DIR_ROWS; row++)
            drive_box(DIRECTED[row].shape, DIRECTED[row].last, DIRECTED[row].typed,
                      DIRECTED[row].want);

        // random frames under several thresholds, extremes included
        phase_thr[0] = '0;
        phase_thr[1] = '1;
        phase_thr[2] = THR_W'($urandom_range(1, 65534));
        phase_thr[3] = 16'd32768;
        phase_thr[4] = THR_W'($urandom_range(1, 65534));
        phase_thr[5] = THR_RESET;
        for (phase = 0; phase < 6; phase++)
        begin
            set_threshold(phase_thr[phase]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                fill = ($urandom_range(0, 5) == 0);
                if (fill)
                    n_boxes = $urandom_range(72, 100);
                else if ($urandom_range(0, 3) == 0)
                    n_boxes = $urandom_range(1, 3);
                else
                    n_boxes = $urandom_range(4, 40);
                send_frame(n_boxes, fill);
                sent += n_boxes;
            end
        end

        hold_until_drained();
        if (err_total == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gbs_pkg.sv
rtl/gbs_box_if.sv
rtl/gbs_res_if.sv
rtl/gbs_iou_unit.sv
rtl/greedy_box_suppression.sv
verif/tb_top.sv
